@@ rtl/kls_pkg.sv @@
// Shared types and constants for the k-th largest selection block.
// Holds the status codes, the queue control struct and the back-end states.
// No dependencies.
`default_nettype none

package kls_pkg;

	localparam int MAX_ITEMS_DEF  = 1024;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int RANK_W         = 11;
	localparam int STATUS_W       = 2;
	localparam int QUEUE_DEPTH    = 4;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_RANK     = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// Classification of one item as handed from front to back.
	typedef struct packed {
		logic    store;
		logic    last;
		status_t status;
	} op_ctl_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_RANGE,
		BK_LEAF_RD,
		BK_LEAF,
		BK_PIV_RD,
		BK_PIV,
		BK_SCAN_RD,
		BK_SCAN_CMP,
		BK_SCAN_SWAP,
		BK_FIN_RD,
		BK_FIN_W1,
		BK_FIN_W2,
		BK_EMIT
	} bk_state_t;

endpackage

`default_nettype wire

@@ rtl/kls_front.sv @@
// Front end: accepts items, tracks the set fill count and overflow, and
// classifies each item (store, drop, select with rank check). Uses kls_pkg.
`default_nettype none

module kls_front
	import kls_pkg::*;
#(
	parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int AW         = $clog2(MAX_ITEMS),
	parameter int CW         = $clog2(MAX_ITEMS + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output      logic                  in_ready,
	input  wire logic [DATA_WIDTH-1:0] value,
	input  wire logic                  last,
	input  wire logic [RANK_W-1:0]     rank_k,
	input  wire logic                  q_full,
	output      logic                  push,
	output      op_ctl_t               ctl,
	output      logic [DATA_WIDTH-1:0] wr_value,
	output      logic [AW-1:0]         addr,
	output      logic [CW-1:0]         target
);

	localparam int RW = (CW > RANK_W) ? CW : RANK_W;

	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic          room;
	logic [CW-1:0] count_n;
	logic          ovf_n;
	logic [RW-1:0] rank_ext;
	logic [RW-1:0] cnt_ext;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;
	assign room     = (count_q < CW'(MAX_ITEMS));
	assign count_n  = room ? (count_q + CW'(1)) : count_q;
	assign ovf_n    = ovf_q || !room;
	assign rank_ext = RW'(rank_k);
	assign cnt_ext  = RW'(count_n);
	assign wr_value = value;
	assign addr     = count_q[AW-1:0];
	assign target   = CW'(cnt_ext - rank_ext + RW'(1));

	always_comb begin
		ctl.store  = room;
		ctl.last   = last;
		if (ovf_n) begin
			ctl.status = ST_OVERFLOW;
		end else if ((rank_k == '0) || (rank_ext > cnt_ext)) begin
			ctl.status = ST_RANK;
		end else begin
			ctl.status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (push) begin
			// the last item closes the set: start over
			if (last) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				count_q <= count_n;
				ovf_q   <= ovf_n;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_set_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(push && last) |=> (count_q == '0))
		else $error("fill count not cleared after last item");
`endif

endmodule

`default_nettype wire

@@ rtl/kls_queue.sv @@
// Short FIFO between front and back ends of the selection block.
// Generic width; depth taken from kls_pkg.
`default_nettype none

module kls_queue
	import kls_pkg::*;
#(
	parameter int W     = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] din,
	output      logic         full,
	output      logic         not_empty,
	input  wire logic         pop,
	output      logic [W-1:0] dout
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (cnt_q == NW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign dout      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + NW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NW'(DEPTH))
		else $error("queue count beyond depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

@@ rtl/kls_back.sv @@
// Back end: element memory plus the quickselect sequencer (Lomuto partition,
// last element as pivot) and the result register. Uses kls_pkg.
`default_nettype none

module kls_back
	import kls_pkg::*;
#(
	parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int AW         = $clog2(MAX_ITEMS),
	parameter int CW         = $clog2(MAX_ITEMS + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_valid,
	input  wire op_ctl_t               q_ctl,
	input  wire logic [DATA_WIDTH-1:0] q_value,
	input  wire logic [AW-1:0]         q_addr,
	input  wire logic [CW-1:0]         q_target,
	output      logic                  q_pop,
	output      logic                  out_valid,
	input  wire logic                  out_ready,
	output      logic [DATA_WIDTH-1:0] kth_value,
	output      logic [STATUS_W-1:0]   status
);

	logic [DATA_WIDTH-1:0] mem [MAX_ITEMS];

	bk_state_t             state_q;
	bk_state_t             state_n;
	logic [AW-1:0]         lo_q;
	logic [AW-1:0]         hi_q;
	logic [CW-1:0]         tgt_q;
	logic [AW-1:0]         i_q;
	logic [AW-1:0]         j_q;
	logic [DATA_WIDTH-1:0] pivot_q;
	logic [DATA_WIDTH-1:0] rd_a_q;
	logic [DATA_WIDTH-1:0] rd_b_q;
	logic [DATA_WIDTH-1:0] sel_value_q;
	status_t               sel_status_q;
	logic [DATA_WIDTH-1:0] out_value_q;
	status_t               out_status_q;
	logic                  res_valid_q;

	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [DATA_WIDTH-1:0] mem_wdata;
	logic [AW-1:0]         raddr_a;
	logic                  res_load;
	logic                  le;
	logic                  j_last;
	logic [CW-1:0]         here;

	assign le        = ($signed(rd_b_q) <= $signed(pivot_q));
	assign j_last    = ((j_q + AW'(1)) == hi_q);
	assign here      = CW'(i_q) - CW'(lo_q) + CW'(1);
	assign out_valid = res_valid_q;
	assign kth_value = out_value_q;
	assign status    = out_status_q;

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid && q_ctl.last) begin
					state_n = (q_ctl.status == ST_OK) ? BK_RANGE : BK_EMIT;
				end
			end
			BK_RANGE:     state_n = (lo_q >= hi_q) ? BK_LEAF_RD : BK_PIV_RD;
			BK_LEAF_RD:   state_n = BK_LEAF;
			BK_LEAF:      state_n = BK_EMIT;
			BK_PIV_RD:    state_n = BK_PIV;
			BK_PIV:       state_n = BK_SCAN_RD;
			BK_SCAN_RD:   state_n = BK_SCAN_CMP;
			BK_SCAN_CMP: begin
				if (le) begin
					state_n = BK_SCAN_SWAP;
				end else begin
					state_n = j_last ? BK_FIN_RD : BK_SCAN_RD;
				end
			end
			BK_SCAN_SWAP: state_n = j_last ? BK_FIN_RD : BK_SCAN_RD;
			BK_FIN_RD:    state_n = BK_FIN_W1;
			BK_FIN_W1:    state_n = BK_FIN_W2;
			BK_FIN_W2:    state_n = (tgt_q == here) ? BK_EMIT : BK_RANGE;
			BK_EMIT: begin
				if (!res_valid_q || out_ready) begin
					state_n = BK_IDLE;
				end
			end
			default:      state_n = BK_IDLE;
		endcase
	end

	// memory ports and handshakes
	always_comb begin
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = i_q;
		mem_wdata = rd_a_q;
		raddr_a   = i_q;
		res_load  = 1'b0;
		case (state_q)
			BK_IDLE: begin
				q_pop     = q_valid;
				mem_we    = q_valid && q_ctl.store;
				mem_waddr = q_addr;
				mem_wdata = q_value;
			end
			BK_LEAF_RD: raddr_a = lo_q;
			BK_PIV_RD:  raddr_a = hi_q;
			BK_SCAN_CMP: begin
				mem_we    = le;
				mem_waddr = i_q;
				mem_wdata = rd_b_q;
			end
			BK_SCAN_SWAP: begin
				mem_we    = 1'b1;
				mem_waddr = j_q;
				mem_wdata = rd_a_q;
			end
			BK_FIN_W1: begin
				mem_we    = 1'b1;
				mem_waddr = hi_q;
				mem_wdata = rd_a_q;
			end
			BK_FIN_W2: begin
				mem_we    = 1'b1;
				mem_waddr = i_q;
				mem_wdata = pivot_q;
			end
			BK_EMIT: res_load = !res_valid_q || out_ready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_a_q <= mem[raddr_a];
		rd_b_q <= mem[j_q];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (q_valid && q_ctl.last) begin
					lo_q         <= '0;
					hi_q         <= q_addr;
					tgt_q        <= q_target;
					sel_value_q  <= '0;
					sel_status_q <= q_ctl.status;
				end
			end
			BK_LEAF: sel_value_q <= rd_a_q;
			BK_PIV_RD: begin
				i_q <= lo_q;
				j_q <= lo_q;
			end
			BK_PIV: pivot_q <= rd_a_q;
			BK_SCAN_CMP: begin
				if (!le) begin
					j_q <= j_q + AW'(1);
				end
			end
			BK_SCAN_SWAP: begin
				i_q <= i_q + AW'(1);
				j_q <= j_q + AW'(1);
			end
			BK_FIN_W2: begin
				// pivot now sits at i: keep the side that holds the target
				if (tgt_q == here) begin
					sel_value_q <= pivot_q;
				end else if (tgt_q < here) begin
					hi_q <= i_q - AW'(1);
				end else begin
					lo_q  <= i_q + AW'(1);
					tgt_q <= tgt_q - here;
				end
			end
			default: begin
			end
		endcase
		if (res_load) begin
			out_value_q  <= sel_value_q;
			out_status_q <= sel_status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (out_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SCAN_CMP) |-> ((i_q <= j_q) && (j_q < hi_q)))
		else $error("partition indexes out of order");
	a_target_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_RANGE) |-> ((tgt_q != '0) &&
			(tgt_q <= CW'(hi_q) - CW'(lo_q) + CW'(1))))
		else $error("target rank outside working range");
`endif

endmodule

`default_nettype wire

@@ rtl/kth_largest_quickselect_top.sv @@
// Top level of the k-th largest selection block: rank register, front end,
// item queue and quickselect back end. Uses kls_pkg, kls_front, kls_queue, kls_back.
`default_nettype none

// Items stream in one per cycle while the queue has room and queue up; the
// back end writes one element per cycle into its memory while it is idle.
// On the last item of a set with an OK status it runs quickselect on a memory
// with two read ports and one write port: each partition pass over a range
// checks the range, reads the pivot, scans the range (read, compare, and a swap
// for each element not above the pivot), then does the final swap and narrows
// the range, until the target rank is found. Results with an error status go
// straight to the emit state. The rank register is written through the cfg
// channel; the user must write it only while the block is idle, as the block
// does not enforce this. The element memory needs no clearing after reset.
module kth_largest_quickselect_top
	import kls_pkg::*;
#(
	parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output      logic                  cfg_ready,
	input  wire logic [RANK_W-1:0]     rank_k,
	input  wire logic                  in_valid,
	output      logic                  in_ready,
	input  wire logic [DATA_WIDTH-1:0] value,
	input  wire logic                  last,
	output      logic                  out_valid,
	input  wire logic                  out_ready,
	output      logic [DATA_WIDTH-1:0] kth_value,
	output      logic [STATUS_W-1:0]   status
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int QW = $bits(op_ctl_t) + DATA_WIDTH + AW + CW;

	logic [RANK_W-1:0]     rank_q;
	logic                  f_push;
	op_ctl_t               f_ctl;
	logic [DATA_WIDTH-1:0] f_value;
	logic [AW-1:0]         f_addr;
	logic [CW-1:0]         f_target;
	logic                  q_full;
	logic                  q_valid;
	logic                  q_pop;
	logic [QW-1:0]         q_dout;
	op_ctl_t               q_ctl;
	logic [DATA_WIDTH-1:0] q_value;
	logic [AW-1:0]         q_addr;
	logic [CW-1:0]         q_target;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= RANK_W'(1);
		end else if (cfg_valid) begin
			rank_q <= rank_k;
		end
	end

	kls_front #(
		.MAX_ITEMS  (MAX_ITEMS),
		.DATA_WIDTH (DATA_WIDTH),
		.AW         (AW),
		.CW         (CW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.value    (value),
		.last     (last),
		.rank_k   (rank_q),
		.q_full   (q_full),
		.push     (f_push),
		.ctl      (f_ctl),
		.wr_value (f_value),
		.addr     (f_addr),
		.target   (f_target)
	);

	kls_queue #(
		.W     (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.din       ({f_ctl, f_value, f_addr, f_target}),
		.full      (q_full),
		.not_empty (q_valid),
		.pop       (q_pop),
		.dout      (q_dout)
	);

	assign {q_ctl, q_value, q_addr, q_target} = q_dout;

	kls_back #(
		.MAX_ITEMS  (MAX_ITEMS),
		.DATA_WIDTH (DATA_WIDTH),
		.AW         (AW),
		.CW         (CW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ctl     (q_ctl),
		.q_value   (q_value),
		.q_addr    (q_addr),
		.q_target  (q_target),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kth_value (kth_value),
		.status    (status)
	);

endmodule

`default_nettype wire
